// ===== src/ftc_pkg.sv =====
// Shared types, constants and the plane-evaluation micro-program for the
// frustum triangle cull block. No dependencies; every other file imports it.
package ftc_pkg;

  localparam int DEF_MAX_PLANES = 8;
  localparam logic [3:0] PLANE_COUNT_RESET = 4'd5;

  localparam int COORD_W = 32;                  // Q16.16 coordinate
  localparam int H_W     = 31;                  // unsigned Q15.16 height
  localparam int MUL_W   = COORD_W + 1;         // signed multiplier operand
  localparam int PROD_W  = 2 * MUL_W;           // full product
  localparam int W_W     = 2 * COORD_W;         // scaled coordinate, Q32.32
  localparam int ACC_W   = 98;                  // exact dot product accumulator
  localparam int Q_FRAC  = 16;
  localparam int STEP_W  = 4;

  localparam logic [STEP_W-1:0] UNSCALED_LAST = 4'd5;
  localparam logic [STEP_W-1:0] SCALED_LAST   = 4'd11;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_POINT  = 2'd1,
    OP_TRI    = 2'd2,
    OP_VOLUME = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    VERDICT_CONTAINS  = 2'd0,
    VERDICT_INTERSECT = 2'd1,
    VERDICT_OUTSIDE   = 2'd2
  } verdict_e;

  typedef enum logic {
    A_NORMAL,
    A_VERTEX
  } a_sel_e;

  typedef enum logic [2:0] {
    B_VERTEX,
    B_POINT,
    B_HEIGHT,
    B_W_LO,
    B_W_HI
  } b_sel_e;

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_e;

  typedef enum logic [1:0] {
    SH_0,
    SH_FRAC,
    SH_WORD
  } shift_e;

  typedef logic [2:0][COORD_W-1:0] vec3_t;

  typedef struct packed {
    vec3_t normal;
    vec3_t point;
  } plane_t;

  // One micro-op of the shared multiply-accumulate unit
  typedef struct packed {
    logic   valid;
    a_sel_e a_sel;
    b_sel_e b_sel;
    axis_e  axis;
    shift_e shift;
    logic   sub;     // subtract the product instead of adding it
    logic   to_w;    // product goes to the scaled-coordinate register
    logic   first;   // product replaces the accumulator
  } mac_ctl_t;

  // Unscaled pass: n.v - n.d.
  // Scaled pass: per axis w = v*h, then n*w in two halves, then - 2^16 * n.d.
  function automatic mac_ctl_t ftc_uop(input logic [STEP_W-1:0] step,
                                       input logic scaled);
    mac_ctl_t u;
    u.valid = 1'b1;
    u.a_sel = A_NORMAL;
    u.b_sel = B_VERTEX;
    u.axis  = AX_X;
    u.shift = SH_0;
    u.sub   = 1'b0;
    u.to_w  = 1'b0;
    u.first = 1'b0;
    if (!scaled) begin
      case (step)
        4'd0: u.first = 1'b1;
        4'd1: u.axis  = AX_Y;
        4'd2: u.axis  = AX_Z;
        4'd3: begin u.b_sel = B_POINT; u.sub = 1'b1; end
        4'd4: begin u.b_sel = B_POINT; u.sub = 1'b1; u.axis = AX_Y; end
        4'd5: begin u.b_sel = B_POINT; u.sub = 1'b1; u.axis = AX_Z; end
        default: u.valid = 1'b0;
      endcase
    end else begin
      case (step)
        4'd0: begin u.a_sel = A_VERTEX; u.b_sel = B_HEIGHT; u.to_w = 1'b1; end
        4'd1: begin u.b_sel = B_W_LO; u.first = 1'b1; end
        4'd2: begin u.b_sel = B_W_HI; u.shift = SH_WORD; end
        4'd3: begin
          u.a_sel = A_VERTEX; u.b_sel = B_HEIGHT; u.to_w = 1'b1; u.axis = AX_Y;
        end
        4'd4: begin u.b_sel = B_W_LO; u.axis = AX_Y; end
        4'd5: begin u.b_sel = B_W_HI; u.shift = SH_WORD; u.axis = AX_Y; end
        4'd6: begin
          u.a_sel = A_VERTEX; u.b_sel = B_HEIGHT; u.to_w = 1'b1; u.axis = AX_Z;
        end
        4'd7: begin u.b_sel = B_W_LO; u.axis = AX_Z; end
        4'd8: begin u.b_sel = B_W_HI; u.shift = SH_WORD; u.axis = AX_Z; end
        4'd9: begin u.b_sel = B_POINT; u.sub = 1'b1; u.shift = SH_FRAC; end
        4'd10: begin
          u.b_sel = B_POINT; u.sub = 1'b1; u.shift = SH_FRAC; u.axis = AX_Y;
        end
        4'd11: begin
          u.b_sel = B_POINT; u.sub = 1'b1; u.shift = SH_FRAC; u.axis = AX_Z;
        end
        default: u.valid = 1'b0;
      endcase
    end
    return u;
  endfunction

endpackage

// ===== src/ftc_plane_table.sv =====
// Plane table: MAX_PLANES normal/point pairs in flip-flops, cleared at reset.
// One write port from load transactions, one read port for the sequencer. Uses ftc_pkg.
module ftc_plane_table
  import ftc_pkg::*;
#(
  parameter int MAX_PLANES = DEF_MAX_PLANES,
  localparam int TIDX_W = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [TIDX_W-1:0] wr_idx_i,
  input  plane_t            wr_plane_i,
  input  logic [TIDX_W-1:0] rd_idx_i,
  output plane_t            rd_plane_o
);

  plane_t planes_q [MAX_PLANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PLANES; i++) begin
        planes_q[i] <= '0;
      end
    end else if (wr_en_i) begin
      planes_q[wr_idx_i] <= wr_plane_i;
    end
  end

  assign rd_plane_o = planes_q[rd_idx_i];

endmodule

// ===== src/ftc_mac_unit.sv =====
// Shared 33x33 signed multiply-accumulate unit with a scaled-coordinate register.
// Driven one micro-op per cycle by the sequencer; exposes the accumulator sign. Uses ftc_pkg.
module ftc_mac_unit
  import ftc_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mac_ctl_t       ctl_i,
  input  vec3_t          normal_i,
  input  vec3_t          point_i,
  input  vec3_t          vertex_i,
  input  logic [H_W-1:0] height_i,
  output logic           sign_o
);

  logic signed [MUL_W-1:0]  op_a, op_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] p_q;
  logic                     p_valid_q;
  logic                     p_sub_q, p_first_q;
  shift_e                   p_shift_q;
  logic [W_W-1:0]           w_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d, addend, base;
  logic [COORD_W-1:0]       n_sel, v_sel, d_sel;

  assign n_sel = normal_i[ctl_i.axis];
  assign v_sel = vertex_i[ctl_i.axis];
  assign d_sel = point_i[ctl_i.axis];

  always_comb begin
    case (ctl_i.a_sel)
      A_NORMAL: op_a = signed'({n_sel[COORD_W-1], n_sel});
      A_VERTEX: op_a = signed'({v_sel[COORD_W-1], v_sel});
      default:  op_a = '0;
    endcase
    case (ctl_i.b_sel)
      B_VERTEX: op_b = signed'({v_sel[COORD_W-1], v_sel});
      B_POINT:  op_b = signed'({d_sel[COORD_W-1], d_sel});
      B_HEIGHT: op_b = signed'({{(MUL_W-H_W){1'b0}}, height_i});
      B_W_LO:   op_b = signed'({1'b0, w_q[COORD_W-1:0]});
      B_W_HI:   op_b = signed'({w_q[W_W-1], w_q[W_W-1:COORD_W]});
      default:  op_b = '0;
    endcase
  end

  assign prod = op_a * op_b;

  always_comb begin
    addend = {{(ACC_W-PROD_W){p_q[PROD_W-1]}}, p_q};
    case (p_shift_q)
      SH_0:    addend = addend;
      SH_FRAC: addend = addend <<< Q_FRAC;
      SH_WORD: addend = addend <<< COORD_W;
      default: addend = addend;
    endcase
    base  = p_first_q ? '0 : acc_q;
    acc_d = p_sub_q ? base - addend : base + addend;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else begin
      p_valid_q <= ctl_i.valid && !ctl_i.to_w;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q       <= prod;
    p_sub_q   <= ctl_i.sub;
    p_first_q <= ctl_i.first;
    p_shift_q <= ctl_i.shift;
    if (ctl_i.valid && ctl_i.to_w) begin
      w_q <= prod[W_W-1:0];
    end
    if (p_valid_q) begin
      acc_q <= acc_d;
    end
  end

  assign sign_o = acc_q[ACC_W-1];

endmodule

// ===== src/ftc_sequencer.sv =====
// Test sequencer: walks planes, vertices and micro-op steps, counts outside
// vertices and forms the verdict in a holding output register. Uses ftc_pkg.
module ftc_sequencer
  import ftc_pkg::*;
#(
  parameter int MAX_PLANES = DEF_MAX_PLANES,
  localparam int TIDX_W = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  op_e               op_i,
  input  logic [3:0]        plane_count_i,
  input  logic              sign_i,
  input  logic              out_ready_i,
  output logic              idle_o,
  output mac_ctl_t          ctl_o,
  output logic [TIDX_W-1:0] plane_idx_o,
  output logic [1:0]        vtx_idx_o,
  output logic              out_valid_o,
  output verdict_e          verdict_o
);

  localparam int CNT_W = $clog2(MAX_PLANES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_EVAL,
    S_HOLD
  } state_e;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [CNT_W-1:0]  plane_q, plane_d, n_eff, plane_inc;
  logic [1:0]        vtx_q, vtx_d, rej_q, rej_d, rej_new;
  logic              scaled_q, scaled_d, inter_q, inter_d, inter_new;
  op_e               op_q, op_d;
  logic              out_valid_q, out_valid_d;
  verdict_e          verdict_q, verdict_d, pend_q, pend_d, fin_verdict;
  logic              finish, next_plane, last_step;

  assign n_eff = (int'(plane_count_i) > MAX_PLANES) ? CNT_W'(MAX_PLANES)
                                                    : CNT_W'(plane_count_i);
  assign plane_inc = CNT_W'(plane_q + 1'b1);
  assign rej_new   = 2'(rej_q + {1'b0, sign_i});
  assign last_step = scaled_q ? (step_q == SCALED_LAST) : (step_q == UNSCALED_LAST);

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    plane_d     = plane_q;
    vtx_d       = vtx_q;
    rej_d       = rej_q;
    scaled_d    = scaled_q;
    inter_d     = inter_q;
    op_d        = op_q;
    pend_d      = pend_q;
    finish      = 1'b0;
    next_plane  = 1'b0;
    inter_new   = inter_q;
    fin_verdict = VERDICT_CONTAINS;

    // drop the shown result once taken
    out_valid_d = out_valid_q && !out_ready_i;
    verdict_d   = verdict_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d     = op_i;
          plane_d  = '0;
          vtx_d    = '0;
          rej_d    = '0;
          scaled_d = 1'b0;
          inter_d  = 1'b0;
          step_d   = '0;
          if (n_eff == '0) begin
            finish = 1'b1;
          end else begin
            state_d = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (last_step) begin
          state_d = S_DRAIN;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_DRAIN: state_d = S_EVAL;
      S_EVAL: begin
        step_d  = '0;
        state_d = S_RUN;
        if (op_q == OP_POINT) begin
          if (sign_i) begin
            finish      = 1'b1;
            fin_verdict = VERDICT_OUTSIDE;
          end else begin
            next_plane = 1'b1;
          end
        end else if (vtx_q != 2'd2) begin
          vtx_d = vtx_q + 1'b1;
          rej_d = rej_new;
        end else if (!scaled_q) begin
          if (rej_new == 2'd3) begin
            if (op_q == OP_TRI) begin
              finish      = 1'b1;
              fin_verdict = VERDICT_OUTSIDE;
            end else begin
              // all three outside: confirm with the height-scaled vertices
              scaled_d = 1'b1;
              vtx_d    = '0;
              rej_d    = '0;
            end
          end else begin
            inter_new  = inter_q || (rej_new != 2'd0);
            next_plane = 1'b1;
          end
        end else begin
          if (rej_new == 2'd3) begin
            finish      = 1'b1;
            fin_verdict = VERDICT_OUTSIDE;
          end else begin
            inter_new  = 1'b1;
            next_plane = 1'b1;
          end
        end
        if (next_plane) begin
          inter_d  = inter_new;
          vtx_d    = '0;
          rej_d    = '0;
          scaled_d = 1'b0;
          if (plane_inc == n_eff) begin
            finish      = 1'b1;
            fin_verdict = inter_new ? VERDICT_INTERSECT : VERDICT_CONTAINS;
          end else begin
            plane_d = plane_inc;
          end
        end
      end
      S_HOLD: begin
        if (out_ready_i) begin
          out_valid_d = 1'b1;
          verdict_d   = pend_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (finish) begin
      if (!out_valid_q || out_ready_i) begin
        out_valid_d = 1'b1;
        verdict_d   = fin_verdict;
        state_d     = S_IDLE;
      end else begin
        // hold the verdict until the previous transaction is taken
        pend_d  = fin_verdict;
        state_d = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      plane_q     <= '0;
      vtx_q       <= '0;
      rej_q       <= '0;
      scaled_q    <= 1'b0;
      inter_q     <= 1'b0;
      op_q        <= OP_LOAD;
      out_valid_q <= 1'b0;
      verdict_q   <= VERDICT_CONTAINS;
      pend_q      <= VERDICT_CONTAINS;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      plane_q     <= plane_d;
      vtx_q       <= vtx_d;
      rej_q       <= rej_d;
      scaled_q    <= scaled_d;
      inter_q     <= inter_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
      verdict_q   <= verdict_d;
      pend_q      <= pend_d;
    end
  end

  always_comb begin
    ctl_o = ftc_uop(step_q, scaled_q);
    if (state_q != S_RUN) begin
      ctl_o.valid = 1'b0;
    end
  end

  assign idle_o      = (state_q == S_IDLE);
  assign plane_idx_o = plane_q[TIDX_W-1:0];
  assign vtx_idx_o   = vtx_q;
  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

endmodule

// ===== src/frustum_triangle_cull_top.sv =====
// Frustum triangle cull. One plane-evaluation MAC unit runs each vertex pass, unscaled
// or scaled. A point test runs an unscaled pass of vertex a for at most each active plane,
// a triangle test one for each vertex and plane, and a volume test adds a scaled pass of
// all three vertices for each plane with all vertices outside; n = active planes.
// Throughput: a load or an n = 0 test every cycle, else one test at a time.
// A full output register holds back the input. Reset clears the table, plane_count = 5.
module frustum_triangle_cull_top
  import ftc_pkg::*;
#(
  parameter int MAX_PLANES = DEF_MAX_PLANES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [3:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          op_i,
  input  logic [2:0]          plane_index_i,
  input  logic [COORD_W-1:0]  vert_a_x_i,
  input  logic [COORD_W-1:0]  vert_a_y_i,
  input  logic [COORD_W-1:0]  vert_a_z_i,
  input  logic [COORD_W-1:0]  vert_b_x_i,
  input  logic [COORD_W-1:0]  vert_b_y_i,
  input  logic [COORD_W-1:0]  vert_b_z_i,
  input  logic [COORD_W-1:0]  vert_c_x_i,
  input  logic [COORD_W-1:0]  vert_c_y_i,
  input  logic [COORD_W-1:0]  vert_c_z_i,
  input  logic [H_W-1:0]      height_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          verdict_o
);

  localparam int TIDX_W = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;

  logic              in_acc, idle, wr_en, sign;
  logic [3:0]        plane_count_q;
  vec3_t             vert_q [3];
  logic [H_W-1:0]    height_q;
  plane_t            wr_plane, rd_plane;
  mac_ctl_t          ctl;
  logic [TIDX_W-1:0] plane_idx;
  logic [1:0]        vtx_idx;
  verdict_e          verdict;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = idle;
  assign in_acc      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_count_q <= PLANE_COUNT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      plane_count_q <= cfg_data_i;
    end
  end

  // capture the test vertices and height of each transaction
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      vert_q[0] <= {vert_a_z_i, vert_a_y_i, vert_a_x_i};
      vert_q[1] <= {vert_b_z_i, vert_b_y_i, vert_b_x_i};
      vert_q[2] <= {vert_c_z_i, vert_c_y_i, vert_c_x_i};
      height_q  <= height_i;
    end
  end

  assign wr_en = in_acc && (op_e'(op_i) == OP_LOAD) && (int'(plane_index_i) < MAX_PLANES);
  assign wr_plane.normal = {vert_a_z_i, vert_a_y_i, vert_a_x_i};
  assign wr_plane.point  = {vert_b_z_i, vert_b_y_i, vert_b_x_i};

  ftc_plane_table #(
    .MAX_PLANES(MAX_PLANES)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_idx_i   (TIDX_W'(plane_index_i)),
    .wr_plane_i (wr_plane),
    .rd_idx_i   (plane_idx),
    .rd_plane_o (rd_plane)
  );

  ftc_mac_unit u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .normal_i (rd_plane.normal),
    .point_i  (rd_plane.point),
    .vertex_i (vert_q[vtx_idx]),
    .height_i (height_q),
    .sign_o   (sign)
  );

  ftc_sequencer #(
    .MAX_PLANES(MAX_PLANES)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (in_acc && (op_e'(op_i) != OP_LOAD)),
    .op_i          (op_e'(op_i)),
    .plane_count_i (plane_count_q),
    .sign_i        (sign),
    .out_ready_i   (out_ready_i),
    .idle_o        (idle),
    .ctl_o         (ctl),
    .plane_idx_o   (plane_idx),
    .vtx_idx_o     (vtx_idx),
    .out_valid_o   (out_valid_o),
    .verdict_o     (verdict)
  );

  assign verdict_o = verdict;

endmodule

// ===== src/ftc_checker.sv =====
// Port-level checker for the frustum triangle cull top, attached by bind.
// Uses ftc_pkg; tracks plane_count from configuration transactions.
module ftc_checker
  import ftc_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic [3:0]         cfg_data_i,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [1:0]         op_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [1:0]         verdict_o
);

  logic [3:0] count_q;
  logic       test_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= PLANE_COUNT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      count_q <= cfg_data_i;
    end
  end

  assign test_acc = in_valid_i && in_ready_o && (op_i != OP_LOAD);

  // result transaction holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(verdict_o))
    else $error("result changed or dropped while stalled");

  // a test against at least one plane keeps the input side closed
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    test_acc && (count_q != 4'd0) |=> !in_ready_o)
    else $error("input ready while a test is running");

  // a load never produces a result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (op_i == OP_LOAD) && !out_valid_o |=> !out_valid_o)
    else $error("load transaction produced a result");

  // no active planes: contains at once
  a_no_planes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    test_acc && (count_q == 4'd0) && !out_valid_o
      |=> out_valid_o && (verdict_o == VERDICT_CONTAINS))
    else $error("empty plane set did not give contains");

endmodule

bind frustum_triangle_cull_top ftc_checker u_ftc_checker (.*);
